[sv/b64d_pkg.sv]
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants of the base64 stream decoder
// Holds the item layouts passed between the decode stage and the result
// queue, and the sizing of that queue.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Default width of the running decoded-byte counter.
  localparam int LENGTH_BITS_DEF = 16;

  // Result queue: deep enough that up to two items in flight, each giving
  // up to three results, always find room.
  localparam int MAX_RESULTS = 3;
  localparam int Q_DEPTH     = 16;
  localparam int Q_AW        = $clog2(Q_DEPTH);
  localparam int Q_CW        = Q_AW + 1;
  localparam int READY_LIMIT = Q_DEPTH - 2 * MAX_RESULTS;

  // One accepted input item, as held in the input register.
  typedef struct packed {
    logic       has_char;
    logic [7:0] in_char;
    logic       end_of_text;
  } in_item_t;

  // One result item, as held in the result queue.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        last_result;
    logic [15:0] total_length;
  } res_item_t;

endpackage

[sv/b64d_in_if.sv]
// ----------------------------------------------------------------------------
// b64d_in_if: input character channel
// Valid/ready channel carrying one base64 character and the end flag.
// ----------------------------------------------------------------------------
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic       has_char;
  logic [7:0] in_char;
  logic       end_of_text;

  modport source (output valid, output has_char, output in_char, output end_of_text,
                  input ready);
  modport sink (input valid, input has_char, input in_char, input end_of_text,
                output ready);
endinterface

[sv/b64d_out_if.sv]
// ----------------------------------------------------------------------------
// b64d_out_if: decoded byte channel
// Valid/ready channel carrying one decoded byte with its end marking.
// ----------------------------------------------------------------------------
interface b64d_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        byte_valid;
  logic        last_result;
  logic [15:0] total_length;

  modport source (output valid, output data_byte, output byte_valid,
                  output last_result, output total_length, input ready);
  modport sink (input valid, input data_byte, input byte_valid,
                input last_result, input total_length, output ready);
endinterface

[sv/b64d_group.sv]
// ----------------------------------------------------------------------------
// b64d_group: input register and group decode
// Registers each accepted item, maps it to a sextet, collects groups of four
// and forms up to three result items in one pass.
// ----------------------------------------------------------------------------
module b64d_group #(
  parameter int LENGTH_BITS = b64d_pkg::LENGTH_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_fire,
  input  b64d_pkg::in_item_t          in_item,
  output logic                        push_v,
  output logic [1:0]                  push_n,
  output b64d_pkg::res_item_t [2:0]   push_ent
);
  import b64d_pkg::*;

  localparam int TW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_PAD   = 8'h3d;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5a;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7a;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [7:0] LC_BASE  = 8'd26;
  localparam logic [7:0] DG_BASE  = 8'd52;
  localparam logic [5:0] SX_PLUS  = 6'd62;
  localparam logic [5:0] SX_HIGH  = 6'd63;

  function automatic logic is_kept(input logic [7:0] c);
    return (c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z) ||
           (c >= CH_D0 && c <= CH_D9) || c == CH_PLUS || c == CH_SLASH ||
           c == CH_PAD;
  endfunction

  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'(SX_HIGH);
    if (c >= CH_UC_A && c <= CH_UC_Z) begin
      t = c - CH_UC_A;
    end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
      t = c - CH_LC_A + LC_BASE;
    end else if (c >= CH_D0 && c <= CH_D9) begin
      t = c - CH_D0 + DG_BASE;
    end else if (c == CH_PLUS) begin
      t = 8'(SX_PLUS);
    end
    return t[5:0];
  endfunction

  // Input register
  logic                   s_v_r;
  in_item_t               s_item_r;

  // Group state
  logic [1:0]             fill_r, fill_nxt;
  logic [2:0][5:0]        held_r, held_nxt;
  logic                   third_pad_r, third_pad_nxt;
  logic [LENGTH_BITS-1:0] total_r, total_nxt;

  logic                   kept, is_pad, em_go, em_p3, em_p4;
  logic [5:0]             sx, e_s1, e_s2, e_s3, e_s4;
  logic [7:0]             b0, b1, b2;
  logic [1:0]             nb;
  logic [LENGTH_BITS:0]   sum;
  logic [LENGTH_BITS-1:0] total_sat;
  logic [TW-1:0]          total_ext;
  logic [15:0]            total_rep;
  logic                   at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r       <= 1'b0;
      fill_r      <= '0;
      held_r      <= '0;
      third_pad_r <= 1'b0;
      total_r     <= '0;
    end else begin
      s_v_r       <= in_fire;
      fill_r      <= fill_nxt;
      held_r      <= held_nxt;
      third_pad_r <= third_pad_nxt;
      total_r     <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_item_r <= in_item;
    end
  end

  // Group collection and the choice of which four sextets to emit.
  always_comb begin
    kept          = s_item_r.has_char && is_kept(s_item_r.in_char);
    sx            = sextet_of(s_item_r.in_char);
    is_pad        = (s_item_r.in_char == CH_PAD);
    at_end        = s_v_r && s_item_r.end_of_text;
    fill_nxt      = fill_r;
    held_nxt      = held_r;
    third_pad_nxt = third_pad_r;
    em_go         = 1'b0;
    em_p3         = 1'b0;
    em_p4         = 1'b0;
    e_s1          = '0;
    e_s2          = '0;
    e_s3          = '0;
    e_s4          = '0;
    if (s_v_r && kept) begin
      if (fill_r == 2'd3) begin
        em_go         = 1'b1;
        e_s1          = held_r[0];
        e_s2          = held_r[1];
        e_s3          = held_r[2];
        e_s4          = sx;
        em_p3         = third_pad_r;
        em_p4         = is_pad;
        fill_nxt      = '0;
        held_nxt      = '0;
        third_pad_nxt = 1'b0;
      end else begin
        held_nxt[fill_r] = sx;
        if (fill_r == 2'd2) begin
          third_pad_nxt = is_pad;
        end
        fill_nxt = fill_r + 2'd1;
      end
    end
    // Flush of a partial group: unfilled slots already hold zero ('A').
    if (at_end && fill_nxt != 2'd0) begin
      em_go         = 1'b1;
      e_s1          = held_nxt[0];
      e_s2          = held_nxt[1];
      e_s3          = held_nxt[2];
      e_s4          = '0;
      em_p3         = (fill_nxt == 2'd3) && third_pad_nxt;
      em_p4         = 1'b0;
      fill_nxt      = '0;
      held_nxt      = '0;
      third_pad_nxt = 1'b0;
    end
  end

  // Byte formation, length count and result items.
  always_comb begin
    b0 = {e_s1, e_s2[5:4]};
    b1 = {e_s2[3:0], e_s3[5:2]};
    b2 = {e_s3[1:0], e_s4};
    nb = em_go ? (2'd1 + 2'(!em_p3) + 2'(!em_p4)) : 2'd0;

    sum       = {1'b0, total_r} + (LENGTH_BITS+1)'(nb);
    total_sat = sum[LENGTH_BITS] ? LEN_MAX : sum[LENGTH_BITS-1:0];
    total_ext = TW'(total_sat);
    total_rep = (total_ext > TW'(16'hffff)) ? 16'hffff : total_ext[15:0];
    total_nxt = at_end ? '0 : (s_v_r ? total_sat : total_r);

    push_v = s_v_r && (nb != 2'd0 || s_item_r.end_of_text);
    push_n = (nb == 2'd0) ? 2'd1 : nb;

    for (int i = 0; i < MAX_RESULTS; i++) begin
      push_ent[i].byte_valid   = (nb != 2'd0);
      push_ent[i].last_result  = at_end && (2'(i) == push_n - 2'd1);
      push_ent[i].total_length = push_ent[i].last_result ? total_rep : 16'd0;
    end
    push_ent[0].data_byte = b0;
    push_ent[1].data_byte = em_p3 ? b2 : b1;
    push_ent[2].data_byte = b2;
  end

endmodule

[sv/b64d_out_queue.sv]
// ----------------------------------------------------------------------------
// b64d_out_queue: result queue
// Takes up to three result items per cycle, hands out one per cycle on pop.
// ----------------------------------------------------------------------------
module b64d_out_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push_v,
  input  logic [1:0]                  push_n,
  input  b64d_pkg::res_item_t [2:0]   push_ent,
  input  logic                        pop,
  output b64d_pkg::res_item_t         head,
  output logic                        not_empty,
  output logic                        can_take
);
  import b64d_pkg::*;

  res_item_t       mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;
  logic [1:0]      n_in;
  logic            do_pop;

  always_comb begin
    n_in       = push_v ? push_n : 2'd0;
    do_pop     = pop && not_empty;
    wr_ptr_nxt = wr_ptr_r + Q_AW'(n_in);
    rd_ptr_nxt = rd_ptr_r + Q_AW'(do_pop);
    count_nxt  = count_r + Q_CW'(n_in) - Q_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (push_v && 2'(i) < push_n) begin
        mem_r[wr_ptr_r + Q_AW'(i)] <= push_ent[i];
      end
    end
  end

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign can_take  = (count_r <= Q_CW'(READY_LIMIT));

endmodule

[sv/base64_stream_decoder_top.sv]
// ----------------------------------------------------------------------------
// base64_stream_decoder_top: streaming base64 text decoder
// Decodes base64 characters, one per input item, into bytes, one per result.
// ----------------------------------------------------------------------------
// Usage:
// The input channel in_ch carries one character per item with has_char and
// end_of_text; characters outside the base64 alphabet are dropped. The
// result channel out_ch carries one decoded byte per item. The last result of
// a text has last_result set and total_length holding the decoded byte count
// (saturating); an end item with nothing left to decode yields one result
// with byte_valid low.
// Throughput: one input item per cycle while in_ch.ready is high, and one
// result per cycle while out_ch.ready is high. A group of four characters
// gives up to three results, so a continuous stream keeps pace. An accepted
// item is held in the input register and decoded from there into the
// result queue; results leave from the head of that queue.
// Reset (rst_n low, synchronous) empties the queue and clears the group and
// the byte count. When the receiver stalls, results wait in a 16-entry queue;
// in_ch.ready falls while more than ten results are waiting.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top #(
  parameter int LENGTH_BITS = b64d_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  b64d_in_if.sink     in_ch,
  b64d_out_if.source  out_ch
);
  import b64d_pkg::*;

  in_item_t        in_item;
  logic            in_fire;
  logic            push_v;
  logic [1:0]      push_n;
  res_item_t [2:0] push_ent;
  res_item_t       head;
  logic            not_empty;
  logic            can_take;

  // The queue always has room for the item being decoded plus one more.
  assign in_ch.ready = can_take;
  assign in_fire     = in_ch.valid && can_take;

  assign in_item.has_char    = in_ch.has_char;
  assign in_item.in_char     = in_ch.in_char;
  assign in_item.end_of_text = in_ch.end_of_text;

  b64d_group #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_group (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_item  (in_item),
    .push_v   (push_v),
    .push_n   (push_n),
    .push_ent (push_ent)
  );

  b64d_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_v    (push_v),
    .push_n    (push_n),
    .push_ent  (push_ent),
    .pop       (out_ch.ready),
    .head      (head),
    .not_empty (not_empty),
    .can_take  (can_take)
  );

  // Results leave straight from the head of the queue.
  assign out_ch.valid        = not_empty;
  assign out_ch.data_byte    = head.data_byte;
  assign out_ch.byte_valid   = head.byte_valid;
  assign out_ch.last_result  = head.last_result;
  assign out_ch.total_length = head.total_length;

endmodule
